// ===== rtl/atsc_pkg.sv =====
// shared types and constants for the adaptive time step controller
// no dependencies
package atsc_pkg;

  localparam int GRID_CELLS = 4096;
  localparam int ADDR_W     = $clog2(GRID_CELLS);
  localparam int CNT_W      = $clog2(GRID_CELLS + 1);
  localparam int TEMP_W     = 32;
  localparam int TIME_W     = 48;
  localparam int HALF_W     = TIME_W / 2;
  localparam int SF_W       = 16;
  localparam int COUNT_W    = 32;
  localparam int NUM_W      = 88;
  localparam int DEN_W      = 64;
  localparam int ITER_W     = $clog2(NUM_W + 1);
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 64;

  // reciprocal constants: floor(x / 1000) for 32-bit x, floor(x / 10) for x below 2^30
  localparam int DIV1000_W  = 29;
  localparam int DIV1000_SH = 38;
  localparam logic [DIV1000_W-1:0] DIV1000_MUL = 29'd274877907;
  localparam int DIV10_W    = 28;
  localparam int DIV10_SH   = 31;
  localparam logic [DIV10_W-1:0] DIV10_MUL = 28'd214748365;
  localparam int REM10_W    = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [1:0] {
    REG_STOP_TIME    = 2'd0,
    REG_MAX_STEP     = 2'd1,
    REG_STEP_FACTOR  = 2'd2,
    REG_INITIAL_STEP = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MINT,
    S_SCAN,
    S_RATIO,
    S_GROW,
    S_CAND,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== rtl/atsc_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on atsc_pkg
module atsc_div import atsc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W:0]    rem_r, rem_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [ITER_W-1:0] iter_r;
  logic              run_r;
  logic              done_r;
  logic [DEN_W+1:0]  shifted;
  logic [DEN_W+1:0]  diff;
  logic              take;

  always_comb begin
    shifted = {rem_r, num_r[NUM_W-1]};
    diff    = shifted - {2'b00, den_r};
    take    = (shifted >= {2'b00, den_r});
    rem_nxt = take ? diff[DEN_W:0] : shifted[DEN_W:0];
    quo_nxt = {quo_r[NUM_W-2:0], take};
    num_nxt = {num_r[NUM_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r  <= 1'b1;
        iter_r <= ITER_W'(NUM_W);
      end else if (run_r) begin
        iter_r <= iter_r - 1'b1;
        if (iter_r == ITER_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (run_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ===== rtl/adaptive_time_step_control_core.sv =====
// adaptive time step controller, top level with cell store and sequencer
// depends on atsc_pkg and atsc_div
//
// Cells are loaded one per cycle while busy is low. After the last cell the
// block is busy in a check state; when the stop time is reached that is all.
// Otherwise follow a setup state, a scan of the store and one or two divisions
// on the shared divider (the second skipped when the ratio quotient is zero),
// then a grow and an update state. The result appears for one cycle on
// out_valid, in the cycle busy falls, and must be taken then.
module adaptive_time_step_control_core import atsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [TEMP_W-1:0]  in_temp_now,
  input  logic [TEMP_W-1:0]  in_temp_before,
  input  logic               in_last_cell,
  output logic               out_valid,
  output logic               out_finished,
  output logic [TIME_W-1:0]  out_step_size,
  output logic [TIME_W-1:0]  out_elapsed_time,
  output logic [COUNT_W-1:0] out_step_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  logic [TIME_W-1:0]  stop_time_r, max_step_r, initial_step_r;
  logic [SF_W-1:0]    step_factor_r;
  reg_idx_t           cfg_idx;

  logic [2*TEMP_W-1:0] mem [GRID_CELLS];
  logic [2*TEMP_W-1:0] rd_data_r;

  state_t state_r, state_nxt;
  logic               launch_r;
  logic [CNT_W-1:0]   cells_r;
  logic [TEMP_W-1:0]  peak_r;
  logic [TIME_W-1:0]  step_r, time_r, dt_r;
  logic [COUNT_W-1:0] count_r;
  logic [TEMP_W-1:0]  min_t_r;
  logic [CNT_W-1:0]   scan_r;
  logic               v1_r, v2_r;
  logic [TEMP_W-1:0]  d_r, dmax_r;
  logic [TEMP_W:0]    den_r, denmax_r;
  logic [DEN_W-1:0]   ratio_r;
  logic [TIME_W-1:0]  grow_r, cand_r;
  logic [HALF_W-1:0]  q_hi_r;
  logic [REM10_W-1:0] r_hi_r;
  logic               scan_done;
  logic               accept;
  logic               wr_en;
  logic [2*TEMP_W+1:0] prod_a, prod_b;
  logic [TEMP_W-1:0]  rd_now, rd_before, rd_diff;
  logic [TIME_W-1:0]  ns;
  logic [TIME_W:0]    time_sum;
  logic [TEMP_W+DIV1000_W-1:0] min_t_prod;
  logic [HALF_W+DIV10_W-1:0]   hi_prod;
  logic [HALF_W-1:0]  hi_tenth, hi_rem;
  logic [HALF_W+REM10_W-1:0]   lo_num;
  logic [HALF_W+REM10_W+DIV10_W-1:0] lo_prod;
  logic [TIME_W:0]    grow_sum;
  logic [TIME_W-1:0]  grow_val;
  logic [SF_W+TIME_W-1:0] sf_dt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               out_valid_r, out_finished_r;
  logic [TIME_W-1:0]  out_step_r, out_time_r;
  logic [COUNT_W-1:0] out_count_r;

  atsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // configuration
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:3]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_time_r    <= TIME_MAX;
      max_step_r     <= TIME_MAX;
      step_factor_r  <= SF_W'(26);
      initial_step_r <= TIME_W'(16777);
    end else if (wr_en) begin
      unique case (cfg_idx)
        REG_STOP_TIME:    stop_time_r    <= pwdata[TIME_W-1:0];
        REG_MAX_STEP:     max_step_r     <= pwdata[TIME_W-1:0];
        REG_STEP_FACTOR:  step_factor_r  <= pwdata[SF_W-1:0];
        REG_INITIAL_STEP: initial_step_r <= pwdata[TIME_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_STOP_TIME:    prdata = CFG_DW'(stop_time_r);
      REG_MAX_STEP:     prdata = CFG_DW'(max_step_r);
      REG_STEP_FACTOR:  prdata = CFG_DW'(step_factor_r);
      REG_INITIAL_STEP: prdata = CFG_DW'(initial_step_r);
    endcase
  end

  // cell store
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept && (cells_r < CNT_W'(GRID_CELLS))) begin
      mem[cells_r[ADDR_W-1:0]] <= {in_temp_now, in_temp_before};
    end
    rd_data_r <= mem[scan_r[ADDR_W-1:0]];
  end

  // scan datapath
  always_comb begin
    rd_now    = rd_data_r[2*TEMP_W-1:TEMP_W];
    rd_before = rd_data_r[TEMP_W-1:0];
    rd_diff   = (rd_before > rd_now) ? rd_before - rd_now : rd_now - rd_before;
    prod_a    = {1'b0, d_r} * {1'b0, denmax_r};
    prod_b    = {1'b0, dmax_r} * {1'b0, den_r};
    scan_done = (scan_r >= cells_r) && !v1_r && !v2_r;
    // peak / 1000 by reciprocal multiplication
    min_t_prod = peak_r * DIV1000_MUL;
    // 1.1 * dt as dt + dt / 10, the tenth taken in two 24-bit halves
    hi_prod   = dt_r[TIME_W-1:HALF_W] * DIV10_MUL;
    hi_tenth  = HALF_W'(hi_prod[HALF_W+DIV10_W-1:DIV10_SH]);
    hi_rem    = dt_r[TIME_W-1:HALF_W]
              - ({hi_tenth[HALF_W-4:0], 3'b000} + {hi_tenth[HALF_W-2:0], 1'b0});
    lo_num    = {r_hi_r, dt_r[HALF_W-1:0]};
    lo_prod   = lo_num * DIV10_MUL;
    grow_sum  = {1'b0, dt_r} + {1'b0, q_hi_r, lo_prod[HALF_W+DIV10_SH-1:DIV10_SH]};
    grow_val  = grow_sum[TIME_W] ? TIME_MAX : grow_sum[TIME_W-1:0];
    sf_dt     = step_factor_r * dt_r;
    ns        = (cand_r < grow_r) ? cand_r : grow_r;
    if (ns > max_step_r) ns = max_step_r;
    time_sum  = {1'b0, time_r} + {1'b0, ns};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept && in_last_cell) state_nxt = S_CHECK;
      S_CHECK:  state_nxt = (time_r >= stop_time_r) ? S_IDLE : S_MINT;
      S_MINT:   state_nxt = S_SCAN;
      S_SCAN:   if (scan_done) state_nxt = S_RATIO;
      S_RATIO:  if (div_rsp.done) state_nxt = S_GROW;
      S_GROW:   state_nxt = (ratio_r == '0) ? S_UPDATE : S_CAND;
      S_CAND:   if (div_rsp.done) state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy          = (state_r != S_IDLE);
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    unique case (state_r)
      S_RATIO: begin
        div_req.start = !launch_r;
        div_req.num   = NUM_W'({dmax_r, 32'h0});
        div_req.den   = DEN_W'(denmax_r);
      end
      S_CAND: begin
        div_req.start = !launch_r;
        div_req.num   = {sf_dt, 24'h0};
        div_req.den   = ratio_r;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= 1'b0;
      cells_r     <= '0;
      peak_r      <= '0;
      step_r      <= '0;
      time_r      <= '0;
      count_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (div_req.start) launch_r <= 1'b1;
      else if (div_rsp.done) launch_r <= 1'b0;

      if (accept && (cells_r < CNT_W'(GRID_CELLS))) begin
        cells_r <= cells_r + 1'b1;
        if (in_temp_now > peak_r) peak_r <= in_temp_now;
      end

      unique case (state_r)
        S_CHECK: begin
          if (time_r >= stop_time_r) begin
            out_valid_r <= 1'b1;
            cells_r     <= '0;
            peak_r      <= '0;
          end
          scan_r <= '0;
        end
        S_SCAN: begin
          v1_r <= (scan_r < cells_r);
          if (scan_r < cells_r) scan_r <= scan_r + 1'b1;
          v2_r <= v1_r;
        end
        S_UPDATE: begin
          step_r      <= ns;
          time_r      <= time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
          if (count_r != '1) count_r <= count_r + 1'b1;
          out_valid_r <= 1'b1;
          cells_r     <= '0;
          peak_r      <= '0;
        end
        default: begin
          v1_r <= 1'b0;
          v2_r <= 1'b0;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_CHECK: begin
        dt_r     <= (count_r == '0) ? initial_step_r : step_r;
        dmax_r   <= '0;
        denmax_r <= (TEMP_W+1)'(1);
        if (time_r >= stop_time_r) begin
          out_finished_r <= 1'b1;
          out_step_r     <= (count_r == '0) ? initial_step_r : step_r;
          out_time_r     <= time_r;
          out_count_r    <= count_r;
        end
      end
      S_MINT: begin
        min_t_r <= TEMP_W'(min_t_prod[TEMP_W+DIV1000_W-1:DIV1000_SH]);
        q_hi_r  <= hi_tenth;
        r_hi_r  <= hi_rem[REM10_W-1:0];
      end
      S_SCAN: begin
        d_r   <= rd_diff;
        den_r <= {1'b0, rd_before} + {1'b0, min_t_r};
        if (v2_r && (den_r != '0) && (prod_a > prod_b)) begin
          dmax_r   <= d_r;
          denmax_r <= den_r;
        end
      end
      S_RATIO: if (div_rsp.done) ratio_r <= div_rsp.quo[DEN_W-1:0];
      S_GROW: begin
        grow_r <= grow_val;
        cand_r <= grow_val;
      end
      S_CAND: begin
        if (div_rsp.done) begin
          cand_r <= (div_rsp.quo > NUM_W'(TIME_MAX)) ? TIME_MAX : div_rsp.quo[TIME_W-1:0];
        end
      end
      S_UPDATE: begin
        out_finished_r <= 1'b0;
        out_step_r     <= ns;
        out_time_r     <= time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];
        out_count_r    <= (count_r != '1) ? count_r + 1'b1 : count_r;
      end
      default: begin
        d_r <= d_r;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_finished     = out_finished_r;
  assign out_step_size    = out_step_r;
  assign out_elapsed_time = out_time_r;
  assign out_step_count   = out_count_r;

  // checks
  a_cells_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cells_r <= CNT_W'(GRID_CELLS))
    else $error("cell count beyond store depth");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on consecutive cycles");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(!rst_n) |-> count_r >= $past(count_r))
    else $error("step count went down");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_IDLE && cells_r == '0)
    else $error("pass not closed after a result");

endmodule
